/* rtl/color_temperature_white_balance_gain_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the white-balance gain block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_WHITE_BALANCE_GAIN_DEFINES_SVH
`define COLOR_TEMPERATURE_WHITE_BALANCE_GAIN_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTWB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTWB_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CTWB_ASSERT(label, clk, rst, prop, msg)
`define CTWB_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* rtl/ctwb_pkg.sv */
// ---------------------------------------------------------------------------
// ctwb_pkg
// Types, fixed-point constants and helpers for the white-balance gain block.
// ---------------------------------------------------------------------------
`default_nettype none
package ctwb_pkg;

   localparam int GAIN_FRAC_BITS = 12;
   localparam int OUT_W          = 14;
   localparam int CHAN_W         = 28;
   localparam int LOG_W          = 34;
   localparam int LOG_LAT        = 32;
   localparam int EXP_LAT        = 50;
   localparam int EXP_TERMS      = 16;

   localparam logic [15:0] KEL_MIN     = 16'd1000;
   localparam logic [15:0] KEL_MAX     = 16'd40000;
   localparam logic [15:0] KEL_KNEE    = 16'd6600;
   localparam logic [15:0] KEL_BLU_LO  = 16'd1900;
   localparam logic [15:0] KEL_POW_OFS = 16'd6000;
   localparam logic [15:0] KEL_BLU_OFS = 16'd1000;

   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   localparam logic [63:0] SCALE_DEN = 64'd10000000000;
   localparam logic [63:0] HALF_DEN  = 64'd5000000000;
   localparam logic [63:0] Q20_MUL   = 64'd1048576;
   localparam logic [63:0] Q30_MUL   = 64'd1073741824;

   localparam logic [29:0] LN2_Q30 =
      30'((64'd6931471806 * Q30_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] RED_EXP =
      30'((64'd1332047592 * Q30_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] GRN_EXP =
      30'((64'd755148492 * Q30_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] RED_COEF =
      30'((64'd3296987274460 * Q20_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] GRN_LOG_COEF =
      30'((64'd994708025861 * Q20_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] GRN_LOG_OFS =
      30'((64'd1611195681661 * Q20_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] GRN_POW_COEF =
      30'((64'd2881221695283 * Q20_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] BLU_LOG_COEF =
      30'((64'd1385177312231 * Q20_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [29:0] BLU_LOG_OFS =
      30'((64'd3050447927307 * Q20_MUL + HALF_DEN) / SCALE_DEN);
   localparam logic [CHAN_W-1:0] FULL_Q20 = CHAN_W'(255) << 20;

   localparam int GG_LIMIT  = 2 << GAIN_FRAC_BITS;
   localparam logic [OUT_W-1:0] GG_MAX =
      (GG_LIMIT > int'(OUT_MAX)) ? OUT_MAX : OUT_W'(GG_LIMIT);

   typedef struct packed {
      logic [15:0]        kelvin;
      logic signed [15:0] tint;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] red_gain;
      logic [OUT_W-1:0] green_gain;
      logic [OUT_W-1:0] blue_gain;
   } rsp_type;

   // log2 of an integer in Q30, by normalising and repeated squaring
   function automatic logic [LOG_W-1:0] log2_q30_f(input logic [15:0] k);
      logic [63:0]      m;
      logic [LOG_W-1:0] res;
      int               b;
      b = 0;
      for (int i = 0; i < 16; i++) begin
         if (k[i]) b = i;
      end
      m   = 64'(k) << (30 - b);
      res = LOG_W'(b) << 30;
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m      = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   localparam logic [LOG_W-1:0] LOG2_100 = log2_q30_f(16'd100);

   function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [35:0] v);
      if (v < 0) begin
         return '0;
      end
      if (v > $signed({8'b0, FULL_Q20})) begin
         return FULL_Q20;
      end
      return v[CHAN_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/ctwb_log2.sv */
// ---------------------------------------------------------------------------
// ctwb_log2
// Pipelined log2(k/100) in Q30: normalise, 30 squaring stages, offset.
// ---------------------------------------------------------------------------
`default_nettype none
module ctwb_log2
   import ctwb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [15:0]      arg,
   output      logic [LOG_W-1:0] log_hund
);

   localparam int STEPS = 30;

   logic [30:0]      m_ff   [0:STEPS];
   logic [LOG_W-1:0] res_ff [0:STEPS];
   logic [LOG_W-1:0] out_ff;

   logic [15:0] k1;
   logic [3:0]  msb;
   logic [46:0] norm;

   always_comb begin
      k1  = (arg == '0) ? 16'd1 : arg;
      msb = '0;
      for (int i = 0; i < 16; i++) begin
         if (k1[i]) msb = 4'(i);
      end
      norm = {31'b0, k1} << (5'd30 - 5'(msb));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]   <= norm[30:0];
         res_ff[0] <= LOG_W'(msb) << 30;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] sh;
      always_comb begin
         sq = 62'(m_ff[s-1]) * 62'(m_ff[s-1]);
         sh = sq[61:30];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[s] <= res_ff[s-1] | (sh[31] ? (LOG_W'(1) << (STEPS - s)) : LOG_W'(0));
            if (sh[31]) begin
               m_ff[s] <= sh[31:1];
            end else begin
               m_ff[s] <= sh[30:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= (res_ff[STEPS] > LOG2_100) ? res_ff[STEPS] - LOG2_100 : '0;
      end
   end

   assign log_hund = out_ff;

endmodule
`default_nettype wire

/* rtl/ctwb_exp2.sv */
// ---------------------------------------------------------------------------
// ctwb_exp2
// Pipelined 2^(-p) in Q30 through a 16-term series, three stages per term.
// ---------------------------------------------------------------------------
`default_nettype none
module ctwb_exp2
   import ctwb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] p,
   output      logic [30:0] pow_neg
);

   localparam int NSTG = 3 * EXP_TERMS;

   typedef struct packed {
      logic [29:0] z;
      logic [1:0]  n;
      logic [30:0] term;
      logic [30:0] pr;
      logic [30:0] q0;
      logic [31:0] sum;
   } exp_stage_type;

   exp_stage_type st_ff [0:NSTG];
   logic [30:0]   out_ff;

   logic [30:0]   g;
   logic [60:0]   zp;
   exp_stage_type st0;

   always_comb begin
      g        = (31'd1 << 30) - {1'b0, p[29:0]};
      zp       = 61'(g) * 61'(LN2_Q30);
      st0.z    = zp[59:30];
      st0.n    = p[31:30];
      st0.term = 31'd1 << 30;
      st0.pr   = '0;
      st0.q0   = '0;
      st0.sum  = 32'd1 << 30;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st0;
      end
   end

   for (genvar s = 1; s <= NSTG; s++) begin : g_stg
      localparam int TI    = (s - 1) / 3 + 1;
      localparam int PHASE = (s - 1) % 3;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TI);
      exp_stage_type stage_in;

      if (PHASE == 0) begin : g_mul
         logic [60:0] prod;
         always_comb begin
            stage_in    = st_ff[s-1];
            prod        = 61'(st_ff[s-1].term) * 61'(st_ff[s-1].z);
            stage_in.pr = prod[60:30];
         end
      end else if (PHASE == 1) begin : g_recip
         logic [63:0] prod;
         always_comb begin
            stage_in    = st_ff[s-1];
            prod        = 64'(st_ff[s-1].pr) * 64'(RECIP);
            stage_in.q0 = prod[62:32];
         end
      end else begin : g_fix
         // quotient estimate is low by at most one
         logic [35:0] qi;
         logic [35:0] rem;
         always_comb begin
            stage_in = st_ff[s-1];
            qi       = 36'(st_ff[s-1].q0) * 36'(TI);
            rem      = 36'(st_ff[s-1].pr) - qi;
            stage_in.term = (rem >= 36'(TI)) ? st_ff[s-1].q0 + 31'd1 : st_ff[s-1].q0;
            stage_in.sum  = st_ff[s-1].sum + 32'(stage_in.term);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= stage_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= 31'(st_ff[NSTG].sum >> (3'(st_ff[NSTG].n) + 3'd1));
      end
   end

   assign pow_neg = out_ff;

endmodule
`default_nettype wire

/* rtl/color_temperature_white_balance_gain.sv */
// ---------------------------------------------------------------------------
// color_temperature_white_balance_gain
// Colour temperature and tint to red, green and blue white-balance gains.
// ---------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle while the output is not stalled.
// The depth is set by the 30 squaring stages of the log2 unit, the 16-term
// exponential series (three stages per term) and the 14-stage restoring
// divider for red and blue over green. A stalled result holds the whole
// pipeline; req_ready stays high while the output stage is empty or being
// taken.
`default_nettype none
`include "color_temperature_white_balance_gain_defines.svh"
module color_temperature_white_balance_gain
   import ctwb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int NUM_W = ((CHAN_W + GAIN_FRAC_BITS) > (CHAN_W + OUT_W) ?
                           (CHAN_W + GAIN_FRAC_BITS) : (CHAN_W + OUT_W)) + 1;

   typedef struct packed {
      logic                  valid;
      logic                  lo;
      logic                  bhi;
      logic                  blo;
      logic [OUT_W-1:0]      gg;
      logic signed [35:0]    grn_lo;
      logic signed [35:0]    blu_v;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [LOG_W-1:0] ln_a;
      logic [LOG_W-1:0] ln_b;
      logic [31:0]      p_r;
      logic [31:0]      p_g;
   } mid_type;

   typedef struct packed {
      side_type    side;
      logic [30:0] red_hi;
      logic [30:0] grn_hi;
   } pow_type;

   typedef struct packed {
      side_type         side;
      logic [CHAN_W-1:0] d;
      logic [NUM_W-1:0] rem_r;
      logic [NUM_W-1:0] rem_b;
      logic [OUT_W-1:0] q_r;
      logic [OUT_W-1:0] q_b;
      logic             ovf_r;
      logic             ovf_b;
   } div_type;

   logic     adv;
   req_type  in_ff;
   logic     in_vld_ff;
   side_type side_in;
   logic [15:0] arg_a, arg_b;
   side_type sa_ff [0:LOG_LAT-1];
   side_type sb_ff [0:EXP_LAT-1];
   logic [LOG_W-1:0] log_a, log_b;
   logic [30:0] e_r, e_g;
   mid_type  m1_ff, m1_in, m2_ff, m2_in;
   pow_type  m3_ff, m3_in;
   div_type  dv_ff [0:OUT_W];
   div_type  dv0_in;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
         in_ff     <= req_data;
      end
   end

   // clamp temperature, pick log arguments, form the tint gain
   logic [15:0]        kel;
   logic signed [17:0] tg;
   logic [15:0]        tgc;
   logic [47:0]        gg_w;
   always_comb begin
      if (in_ff.kelvin < KEL_MIN) begin
         kel = KEL_MIN;
      end else if (in_ff.kelvin > KEL_MAX) begin
         kel = KEL_MAX;
      end else begin
         kel = in_ff.kelvin;
      end
      tg = 18'sd16384 + {{2{in_ff.tint[15]}}, in_ff.tint};
      if (tg < 0) begin
         tgc = '0;
      end else if (tg > 18'sd32768) begin
         tgc = 16'd32768;
      end else begin
         tgc = tg[15:0];
      end
      gg_w = ((48'(tgc) << GAIN_FRAC_BITS) + 48'd8192) >> 14;
      side_in        = '0;
      side_in.valid  = in_vld_ff;
      side_in.lo     = (kel <= KEL_KNEE);
      side_in.bhi    = (kel >= KEL_KNEE);
      side_in.blo    = (kel <= KEL_BLU_LO);
      side_in.gg     = (gg_w > 48'(OUT_MAX)) ? OUT_MAX : gg_w[OUT_W-1:0];
      arg_a = side_in.lo ? kel : kel - KEL_POW_OFS;
      arg_b = kel - KEL_BLU_OFS;
   end

   ctwb_log2 u_log_a (.clock(clock), .en(adv), .arg(arg_a), .log_hund(log_a));
   ctwb_log2 u_log_b (.clock(clock), .en(adv), .arg(arg_b), .log_hund(log_b));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOG_LAT; i++) sa_ff[i] <= '0;
      end else if (adv) begin
         sa_ff[0] <= side_in;
         for (int i = 1; i < LOG_LAT; i++) sa_ff[i] <= sa_ff[i-1];
      end
   end

   // natural logs and power exponents
   logic [63:0] ln_a_p, ln_b_p, pr_p, pg_p;
   always_comb begin
      ln_a_p     = 64'(log_a) * 64'(LN2_Q30);
      ln_b_p     = 64'(log_b) * 64'(LN2_Q30);
      pr_p       = 64'(RED_EXP) * 64'(log_a);
      pg_p       = 64'(GRN_EXP) * 64'(log_a);
      m1_in.side = sa_ff[LOG_LAT-1];
      m1_in.ln_a = ln_a_p[63:30];
      m1_in.ln_b = ln_b_p[63:30];
      m1_in.p_r  = pr_p[61:30];
      m1_in.p_g  = pg_p[61:30];
   end

   // logarithm branches of green and blue
   logic [63:0] gl_p, bl_p;
   always_comb begin
      gl_p  = 64'(GRN_LOG_COEF) * 64'(m1_ff.ln_a);
      bl_p  = 64'(BLU_LOG_COEF) * 64'(m1_ff.ln_b);
      m2_in = m1_ff;
      m2_in.side.grn_lo = $signed({2'b0, gl_p[63:30]}) - $signed(36'(GRN_LOG_OFS));
      m2_in.side.blu_v  = $signed({2'b0, bl_p[63:30]}) - $signed(36'(BLU_LOG_OFS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff <= '0;
         m2_ff <= '0;
      end else if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   ctwb_exp2 u_exp_r (.clock(clock), .en(adv), .p(m2_ff.p_r), .pow_neg(e_r));
   ctwb_exp2 u_exp_g (.clock(clock), .en(adv), .p(m2_ff.p_g), .pow_neg(e_g));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EXP_LAT; i++) sb_ff[i] <= '0;
      end else if (adv) begin
         sb_ff[0] <= m2_ff.side;
         for (int i = 1; i < EXP_LAT; i++) sb_ff[i] <= sb_ff[i-1];
      end
   end

   logic [60:0] rh_p, gh_p;
   always_comb begin
      rh_p         = 61'(RED_COEF) * 61'(e_r);
      gh_p         = 61'(GRN_POW_COEF) * 61'(e_g);
      m3_in.side   = sb_ff[EXP_LAT-1];
      m3_in.red_hi = rh_p[60:30];
      m3_in.grn_hi = gh_p[60:30];
   end

   // select branches, clamp, set up the dividers
   logic [CHAN_W-1:0] red_c, grn_c, blu_c;
   logic [NUM_W-1:0]  d_top;
   always_comb begin
      red_c = m3_ff.side.lo ? FULL_Q20 : clamp_chan($signed({5'b0, m3_ff.red_hi}));
      grn_c = m3_ff.side.lo ? clamp_chan(m3_ff.side.grn_lo)
                            : clamp_chan($signed({5'b0, m3_ff.grn_hi}));
      if (m3_ff.side.bhi) begin
         blu_c = FULL_Q20;
      end else if (m3_ff.side.blo) begin
         blu_c = '0;
      end else begin
         blu_c = clamp_chan(m3_ff.side.blu_v);
      end
      dv0_in.side  = m3_ff.side;
      dv0_in.d     = (grn_c == '0) ? CHAN_W'(1) : grn_c;
      dv0_in.rem_r = (NUM_W'(red_c) << GAIN_FRAC_BITS) + NUM_W'(dv0_in.d >> 1);
      dv0_in.rem_b = (NUM_W'(blu_c) << GAIN_FRAC_BITS) + NUM_W'(dv0_in.d >> 1);
      d_top        = NUM_W'(dv0_in.d) << OUT_W;
      dv0_in.ovf_r = (dv0_in.rem_r >= d_top);
      dv0_in.ovf_b = (dv0_in.rem_b >= d_top);
      dv0_in.q_r   = '0;
      dv0_in.q_b   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_ff    <= '0;
         dv_ff[0] <= '0;
      end else if (adv) begin
         m3_ff    <= m3_in;
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar s = 1; s <= OUT_W; s++) begin : g_div
      localparam int BIT = OUT_W - s;
      div_type          stage_in;
      logic [NUM_W-1:0] dsh;
      always_comb begin
         stage_in = dv_ff[s-1];
         dsh      = NUM_W'(dv_ff[s-1].d) << BIT;
         if (dv_ff[s-1].rem_r >= dsh) begin
            stage_in.rem_r    = dv_ff[s-1].rem_r - dsh;
            stage_in.q_r[BIT] = 1'b1;
         end
         if (dv_ff[s-1].rem_b >= dsh) begin
            stage_in.rem_b    = dv_ff[s-1].rem_b - dsh;
            stage_in.q_b[BIT] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= '0;
         end else if (adv) begin
            dv_ff[s] <= stage_in;
         end
      end
   end

   assign rsp_valid           = dv_ff[OUT_W].side.valid;
   assign rsp_data.red_gain   = dv_ff[OUT_W].ovf_r ? OUT_MAX : dv_ff[OUT_W].q_r;
   assign rsp_data.green_gain = dv_ff[OUT_W].side.gg;
   assign rsp_data.blue_gain  = dv_ff[OUT_W].ovf_b ? OUT_MAX : dv_ff[OUT_W].q_b;

   `CTWB_ASSERT(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready |-> !req_ready, "input taken while result stalled")
   `CTWB_ASSERT(a_green_limit, clock, reset, rsp_valid |-> rsp_data.green_gain <= GG_MAX, "green gain above two")
   `CTWB_NEVER(a_div_rem, clock, reset, dv_ff[OUT_W].side.valid && !dv_ff[OUT_W].ovf_r && (dv_ff[OUT_W].rem_r >= NUM_W'(dv_ff[OUT_W].d)), "red remainder not below divisor")

endmodule
`default_nettype wire
